/* src/sfpf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfpf_pkg
// Shared types and constants of the sync frame parser with Fletcher-8 check.
// ----------------------------------------------------------------------------
package sfpf_pkg;

  localparam int MAX_PAYLOAD_BYTES_DEF = 62;

  localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND = 8'hCA;
  localparam logic [15:0] ERR_MAX     = 16'hFFFF;

  localparam logic STATUS_WORD = 1'b0;
  localparam logic STATUS_ERR  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic hdr;   // header byte taken
    logic id;    // id byte taken
    logic pay;   // payload byte taken
    logic cka;   // check byte A taken
    logic err;   // check byte B taken, sums differ
    logic rd;    // read next payload word
    logic ld;    // load read word into output register
  } sfpf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sync1;     // input byte is first sync
    logic sync2;     // input byte is second sync
    logic hdr_ok;    // header length usable
    logic pay_done;  // this payload byte is the last one
    logic sum_ok;    // both sums match
    logic rd_last;   // word in flight is the last of the frame
    logic out_free;  // output register can load this cycle
  } sfpf_sts_t;

endpackage
`default_nettype wire

/* src/sfpf_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfpf_ctrl
// Frame state machine: sync hunt, header, id, payload, check bytes, drain.
// ----------------------------------------------------------------------------
module sfpf_ctrl
  import sfpf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire sfpf_sts_t sts,
  output sfpf_cmd_t      cmd
);

  localparam logic [3:0] ST_HUNT1 = 4'd0;
  localparam logic [3:0] ST_HUNT2 = 4'd1;
  localparam logic [3:0] ST_HDR   = 4'd2;
  localparam logic [3:0] ST_ID    = 4'd3;
  localparam logic [3:0] ST_PAY   = 4'd4;
  localparam logic [3:0] ST_CKA   = 4'd5;
  localparam logic [3:0] ST_CKB   = 4'd6;
  localparam logic [3:0] ST_DRD   = 4'd7;
  localparam logic [3:0] ST_DLD   = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       take_ok;
  logic       acc;

  always_comb begin
    case (state_r)
      ST_HUNT1, ST_HUNT2, ST_HDR, ST_ID, ST_PAY, ST_CKA: take_ok = 1'b1;
      ST_CKB:  take_ok = sts.out_free;
      default: take_ok = 1'b0;
    endcase
  end

  assign in_stall = !take_ok;
  assign acc      = in_valid && take_ok;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_HUNT1: begin
        if (acc && sts.sync1) state_nxt = ST_HUNT2;
      end
      ST_HUNT2: begin
        if (acc) state_nxt = sts.sync2 ? ST_HDR : ST_HUNT1;
      end
      ST_HDR: begin
        if (acc) begin
          cmd.hdr   = 1'b1;
          state_nxt = sts.hdr_ok ? ST_ID : ST_HUNT1;
        end
      end
      ST_ID: begin
        if (acc) begin
          cmd.id    = 1'b1;
          state_nxt = ST_PAY;
        end
      end
      ST_PAY: begin
        if (acc) begin
          cmd.pay = 1'b1;
          if (sts.pay_done) state_nxt = ST_CKA;
        end
      end
      ST_CKA: begin
        if (acc) begin
          cmd.cka   = 1'b1;
          state_nxt = ST_CKB;
        end
      end
      ST_CKB: begin
        if (acc) begin
          cmd.err   = !sts.sum_ok;
          state_nxt = sts.sum_ok ? ST_DRD : ST_HUNT1;
        end
      end
      ST_DRD: begin
        if (sts.out_free) begin
          cmd.rd    = 1'b1;
          state_nxt = ST_DLD;
        end
      end
      ST_DLD: begin
        cmd.ld    = 1'b1;
        state_nxt = sts.rd_last ? ST_HUNT1 : ST_DRD;
      end
      default: begin
        state_nxt = ST_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT1;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/sfpf_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfpf_dpath
// Fletcher sums, frame fields, payload word store, mismatch counter and
// output register.
// ----------------------------------------------------------------------------
module sfpf_dpath
  import sfpf_pkg::*;
#(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_rx_byte,
  input  wire sfpf_cmd_t   cmd,
  output sfpf_sts_t        sts,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_status,
  output logic [9:0]       out_address,
  output logic [4:0]       out_word_index,
  output logic [15:0]      out_word,
  output logic             out_last,
  output logic [15:0]      out_error_total
);

  localparam int NWORDS = MAX_PAYLOAD_BYTES / 2;
  localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BW     = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam logic [5:0] MAX_LEN = 6'(MAX_PAYLOAD_BYTES);

  logic [7:0]    sum_a_r;
  logic [7:0]    sum_b_r;
  logic [7:0]    sum_a_nxt;
  logic [7:0]    rx_sum_a_r;
  logic [4:0]    wc_r;
  logic [9:0]    addr_r;
  logic [BW-1:0] bytes_seen_r;
  logic [7:0]    hi_r;
  logic [4:0]    idx_r;
  logic [15:0]   rdata_r;
  logic [15:0]   err_cnt_r;
  logic [15:0]   err_cnt_nxt;
  logic          out_valid_r;
  logic          status_r;
  logic [9:0]    address_r;
  logic [4:0]    word_index_r;
  logic [15:0]   word_r;
  logic          last_r;
  logic [15:0]   error_total_r;
  logic [4:0]    hdr_wc;
  logic [15:0]   mem [NWORDS];

  assign hdr_wc      = in_rx_byte[6:2];
  assign sum_a_nxt   = sum_a_r + in_rx_byte;
  assign err_cnt_nxt = (err_cnt_r == ERR_MAX) ? err_cnt_r : err_cnt_r + 16'd1;

  assign sts.sync1    = (in_rx_byte == SYNC_FIRST);
  assign sts.sync2    = (in_rx_byte == SYNC_SECOND);
  assign sts.hdr_ok   = (hdr_wc != 5'd0) && ({hdr_wc, 1'b0} <= MAX_LEN);
  assign sts.pay_done = (6'(bytes_seen_r) + 6'd1) >= {wc_r, 1'b0};
  assign sts.sum_ok   = (sum_a_r == rx_sum_a_r) && (sum_b_r == in_rx_byte);
  assign sts.rd_last  = ((idx_r + 5'd1) == wc_r);
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_a_r      <= '0;
      sum_b_r      <= '0;
      rx_sum_a_r   <= '0;
      wc_r         <= '0;
      addr_r       <= '0;
      bytes_seen_r <= '0;
      idx_r        <= '0;
      err_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.hdr) begin
        sum_a_r      <= in_rx_byte;
        sum_b_r      <= in_rx_byte;
        wc_r         <= hdr_wc;
        addr_r       <= {in_rx_byte[1:0], 8'h00};
        bytes_seen_r <= '0;
        idx_r        <= '0;
      end
      if (cmd.id) begin
        sum_a_r     <= sum_a_nxt;
        sum_b_r     <= sum_b_r + sum_a_nxt;
        addr_r[7:0] <= in_rx_byte;
      end
      if (cmd.pay) begin
        sum_a_r      <= sum_a_nxt;
        sum_b_r      <= sum_b_r + sum_a_nxt;
        bytes_seen_r <= bytes_seen_r + BW'(1);
      end
      if (cmd.cka) rx_sum_a_r <= in_rx_byte;
      if (cmd.err) err_cnt_r <= err_cnt_nxt;
      if (cmd.ld) idx_r <= idx_r + 5'd1;
      if (cmd.err || cmd.ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload store, one big-endian word per entry
  always_ff @(posedge clk) begin
    if (cmd.pay && !bytes_seen_r[0]) hi_r <= in_rx_byte;
    if (cmd.pay && bytes_seen_r[0]) mem[bytes_seen_r[WAW:1]] <= {hi_r, in_rx_byte};
    if (cmd.rd) rdata_r <= mem[idx_r[WAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.err) begin
      status_r      <= STATUS_ERR;
      word_index_r  <= '0;
      word_r        <= '0;
      last_r        <= 1'b1;
      error_total_r <= err_cnt_nxt;
    end else if (cmd.ld) begin
      status_r      <= STATUS_WORD;
      word_index_r  <= idx_r;
      word_r        <= rdata_r;
      last_r        <= sts.rd_last;
      error_total_r <= err_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err || cmd.ld) address_r <= addr_r;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_address     = address_r;
  assign out_word_index  = word_index_r;
  assign out_word        = word_r;
  assign out_last        = last_r;
  assign out_error_total = error_total_r;

endmodule
`default_nettype wire

/* src/sync_frame_parser_fletcher8_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sync_frame_parser_fletcher8_unit
// Byte-serial frame parser: sync 0xAA 0xCA, header, id, payload, Fletcher-8
// check bytes. Emits payload words on a match, one error word on a mismatch.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | word
//  in_     | input     | in_valid / in_stall | in_rx_byte
//  out_    | output    | out_valid/out_stall | status, address, word_index,
//          |           |                     | word, last, error_total
//
// One received byte per cycle while a frame is being parsed; the second check
// byte waits for a free output register. After a matching second check byte
// the input stalls while the payload drains word by word (store read, then
// output register load), longer while out_stall holds the output register.
// A mismatch result needs a free output register when the check byte is taken.
// Reset is synchronous, active low; the payload store needs no clearing.
// ----------------------------------------------------------------------------
module sync_frame_parser_fletcher8_unit
  import sfpf_pkg::*;
#(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_status,
  output logic [9:0]       out_address,
  output logic [4:0]       out_word_index,
  output logic [15:0]      out_word,
  output logic             out_last,
  output logic [15:0]      out_error_total
);

  sfpf_cmd_t cmd;
  sfpf_sts_t sts;

  sfpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfpf_dpath #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_rx_byte      (in_rx_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_address     (out_address),
    .out_word_index  (out_word_index),
    .out_word        (out_word),
    .out_last        (out_last),
    .out_error_total (out_error_total)
  );

endmodule
`default_nettype wire

/* bench/sfpf_frame_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfpf_frame_checker
// Watches both channels of the frame parser. Every accepted received byte
// runs through a bit-true frame decoder that queues the words the block owes.
// Every accepted output word is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module sfpf_frame_checker
  import sfpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_status,
  input  logic [9:0]  out_address,
  input  logic [4:0]  out_word_index,
  input  logic [15:0] out_word,
  input  logic        out_last,
  input  logic [15:0] out_error_total,
  output int          fail_count,
  output int          pending_words
);

  localparam int REPORT_MAX = 10;

  typedef enum logic [2:0] {
    HUNT_SYNC1, HUNT_SYNC2, TAKE_HDR, TAKE_ID, TAKE_PAY, TAKE_CKA, TAKE_CKB
  } parse_phase_t;

  typedef struct packed {
    logic        status;
    logic [9:0]  address;
    logic [4:0]  word_index;
    logic [15:0] word;
    logic        last;
    logic [15:0] error_total;
  } frame_word_t;

  parse_phase_t phase;
  logic [4:0]   n_words;
  logic [9:0]   frame_addr;
  logic [5:0]   n_bytes;
  logic [7:0]   sum_a, sum_b, rx_sum_a;
  logic [15:0]  err_total;
  logic [7:0]   pay_store [MAX_PAYLOAD_BYTES_DEF];
  frame_word_t  owed_words [$];

  function automatic void add_sums(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endfunction

  function automatic void decode_rx_byte(input logic [7:0] b);
    frame_word_t w;
    case (phase)
      HUNT_SYNC2: phase = (b == SYNC_SECOND) ? TAKE_HDR : HUNT_SYNC1;
      TAKE_HDR: begin
        sum_a      = 8'h00;
        sum_b      = 8'h00;
        add_sums(b);
        n_words    = b[6:2];
        frame_addr = {b[1:0], 8'h00};
        n_bytes    = 6'd0;
        if (n_words == 0 || 2 * int'(n_words) > MAX_PAYLOAD_BYTES_DEF)
          phase = HUNT_SYNC1;
        else
          phase = TAKE_ID;
      end
      TAKE_ID: begin
        add_sums(b);
        frame_addr[7:0] = b;
        n_bytes = 6'd0;
        phase = TAKE_PAY;
      end
      TAKE_PAY: begin
        if (int'(n_bytes) < MAX_PAYLOAD_BYTES_DEF) pay_store[n_bytes] = b;
        add_sums(b);
        n_bytes = n_bytes + 6'd1;
        if (int'(n_bytes) >= 2 * int'(n_words)) phase = TAKE_CKA;
      end
      TAKE_CKA: begin
        rx_sum_a = b;
        phase = TAKE_CKB;
      end
      TAKE_CKB: begin
        if (sum_a == rx_sum_a && sum_b == b) begin
          for (int i = 0; i < int'(n_words); i++) begin
            w.status      = STATUS_WORD;
            w.address     = frame_addr;
            w.word_index  = 5'(i);
            w.word        = {pay_store[2 * i], pay_store[2 * i + 1]};
            w.last        = (i + 1 == int'(n_words));
            w.error_total = err_total;
            owed_words.push_back(w);
          end
        end else begin
          if (err_total != ERR_MAX) err_total = err_total + 16'd1;
          w.status      = STATUS_ERR;
          w.address     = frame_addr;
          w.word_index  = 5'd0;
          w.word        = 16'h0000;
          w.last        = 1'b1;
          w.error_total = err_total;
          owed_words.push_back(w);
        end
        sum_a   = 8'h00;
        sum_b   = 8'h00;
        n_bytes = 6'd0;
        phase   = HUNT_SYNC1;
      end
      default: phase = (b == SYNC_FIRST) ? HUNT_SYNC2 : HUNT_SYNC1;
    endcase
  endfunction

  always @(posedge clk) begin
    frame_word_t got, want;
    got = {out_status, out_address, out_word_index, out_word, out_last, out_error_total};
    if (!rst_n) begin
      phase      = HUNT_SYNC1;
      n_words    = 5'd0;
      frame_addr = 10'd0;
      n_bytes    = 6'd0;
      sum_a      = 8'h00;
      sum_b      = 8'h00;
      rx_sum_a   = 8'h00;
      err_total  = 16'd0;
      owed_words.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) decode_rx_byte(in_rx_byte);
      if (out_valid && !out_stall) begin
        if (owed_words.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%0t: unexpected word st=%0d addr=%h idx=%0d w=%h last=%0d err=%0d",
                     $realtime, got.status, got.address, got.word_index, got.word,
                     got.last, got.error_total);
        end else begin
          want = owed_words.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("%0t: word mismatch", $realtime);
              $display("  exp st=%0d addr=%h idx=%0d w=%h last=%0d err=%0d",
                       want.status, want.address, want.word_index, want.word,
                       want.last, want.error_total);
              $display("  got st=%0d addr=%h idx=%0d w=%h last=%0d err=%0d",
                       got.status, got.address, got.word_index, got.word,
                       got.last, got.error_total);
            end
          end
        end
      end
    end
    pending_words = owed_words.size();
  end

endmodule

/* bench/tb_sync_frame_parser_fletcher8_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sync_frame_parser_fletcher8_unit
// Drives received bytes into the frame parser: a short directed run over the
// sync, zero-length and mismatch cases, then mostly well-formed random frames
// mixed with noise and corrupted frames, under four idle/stall mixes with a
// long output hold. The frame checker beside the block scores the words.
// ----------------------------------------------------------------------------
module tb_sync_frame_parser_fletcher8_unit
  import sfpf_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;

  typedef enum int {FLAW_NONE, FLAW_SUM_A, FLAW_SUM_B, FLAW_PAYLOAD} frame_flaw_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_status;
  logic [9:0]  out_address;
  logic [4:0]  out_word_index;
  logic [15:0] out_word;
  logic        out_last;
  logic [15:0] out_error_total;

  int fail_count;
  int pending_words;
  int bytes_sent;
  int idle_pct;
  int stall_pct;
  int hold_requests;
  int cycle_count;

  sync_frame_parser_fletcher8_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_address     (out_address),
    .out_word_index  (out_word_index),
    .out_word        (out_word),
    .out_last        (out_last),
    .out_error_total (out_error_total)
  );

  sfpf_frame_checker frame_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_address     (out_address),
    .out_word_index  (out_word_index),
    .out_word        (out_word),
    .out_last        (out_last),
    .out_error_total (out_error_total),
    .fail_count      (fail_count),
    .pending_words   (pending_words)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stall, or a long hold when one is requested
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // called and returns on a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
  endtask

  // fill < 0 gives random payload bytes
  task automatic send_frame(input int nwords, input logic [9:0] addr,
                            input frame_flaw_t flaw, input int fill);
    logic [7:0] hdr, pay, fa, fb;
    int bad_idx;
    hdr = {1'($urandom_range(1)), 5'(nwords), addr[9:8]};
    fa = hdr;
    fb = hdr;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(hdr);
    if (nwords == 0) return;
    fa = fa + addr[7:0];
    fb = fb + fa;
    send_byte(addr[7:0]);
    bad_idx = $urandom_range(2 * nwords - 1);
    for (int i = 0; i < 2 * nwords; i++) begin
      pay = (fill < 0) ? 8'($urandom) : 8'(fill);
      fa = fa + pay;
      fb = fb + fa;
      if (flaw == FLAW_PAYLOAD && i == bad_idx) pay = pay ^ (8'h01 << $urandom_range(7));
      send_byte(pay);
    end
    send_byte(flaw == FLAW_SUM_A ? fa ^ (8'h01 << $urandom_range(7)) : fa);
    send_byte(flaw == FLAW_SUM_B ? fb ^ (8'h01 << $urandom_range(7)) : fb);
  endtask

  task automatic send_random_traffic();
    int r;
    int nw;
    frame_flaw_t flaw;
    r = $urandom_range(99);
    if (r < 12) begin
      repeat ($urandom_range(5, 1))
        send_byte($urandom_range(3) == 0 ? SYNC_FIRST : 8'($urandom));
    end else if (r < 17) begin
      send_frame(0, 10'($urandom), FLAW_NONE, -1);
    end else begin
      r = $urandom_range(99);
      if (r < 6) nw = 31;
      else if (r < 20) nw = $urandom_range(31, 1);
      else nw = $urandom_range(4, 1);
      r = $urandom_range(99);
      if (r < 5) flaw = FLAW_SUM_A;
      else if (r < 10) flaw = FLAW_SUM_B;
      else if (r < 15) flaw = FLAW_PAYLOAD;
      else flaw = FLAW_NONE;
      send_frame(nw, 10'($urandom), flaw, -1);
    end
  endtask

  initial begin
    int phase_idle [4];
    int phase_stall [4];
    phase_idle  = '{0, 60, 0, 20};
    phase_stall = '{0, 0, 60, 20};
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_rx_byte    <= 8'h00;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_requests = 0;
    bytes_sent    = 0;
    cycle_count   = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // wrong second sync; repeated first sync is not taken as a new start
    send_byte(SYNC_FIRST);
    send_byte(8'h00);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    // zero word count, then extremes of address and payload, then a bad sum
    send_frame(0, 10'h3FF, FLAW_NONE, -1);
    send_frame(1, 10'h3FF, FLAW_NONE, 8'hFF);
    send_frame(1, 10'h000, FLAW_SUM_A, 8'h00);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      if (p == 0) begin
        hold_requests++;
        send_frame(31, 10'($urandom), FLAW_NONE, -1);
        send_frame(3, 10'($urandom), FLAW_NONE, -1);
        send_frame(2, 10'($urandom), FLAW_NONE, -1);
      end
      while (bytes_sent < 24 + 97 * (p + 1)) send_random_traffic();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_words == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
